/* rtl/signed_int_to_decimal_ascii_unit_defines.svh */
// Assertion macros for the signed integer to decimal text unit.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define SITOA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SITOA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SITOA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SITOA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/sitoa_pkg.sv */
// Types and constants for the signed integer to decimal text unit.
// No dependencies.
package sitoa_pkg;

    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int IDX_W      = 4;
    localparam int STEP_W     = 5;

    localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(VALUE_W - 1);
    localparam logic [7:0]        CHAR_ZERO  = 8'd48;
    localparam logic [7:0]        CHAR_NINE  = 8'd57;
    localparam logic [7:0]        CHAR_MINUS = 8'd45;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_PREP = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

endpackage

/* rtl/signed_int_to_decimal_ascii_unit.sv */
// Signed 32-bit integer to decimal ASCII text. An item is accepted in the
// idle state, converted by 32 shift-and-adjust steps of one shared BCD unit,
// and after a leading-digit search in the prep state gives one character per
// cycle while the output is not stalled. A new item is accepted only after the
// last character of the previous one has been issued.
// Reset (aresetn low, synchronous) returns the sequencer to idle, empty output.
`include "signed_int_to_decimal_ascii_unit_defines.svh"

module signed_int_to_decimal_ascii_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_character,
    output logic        m_last_char
);
    import sitoa_pkg::*;

    state_t               state_reg, state_next;
    logic [VALUE_W-1:0]   mag_reg, mag_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [BCD_W-1:0]     bcd_adj;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     top_idx;
    logic                 neg_reg, neg_next;
    logic                 m_valid_reg, m_valid_next;
    logic [7:0]           m_char_reg, m_char_next;
    logic                 m_last_reg, m_last_next;
    logic                 out_free;
    logic [3:0]           cur_digit;

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_character = m_char_reg;
    assign m_last_char = m_last_reg;
    assign out_free    = !m_valid_reg || m_ready;

    // Shared step unit: every BCD digit of five or more gets three added
    // before the whole register shifts left by one.
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // Highest nonzero digit; zero itself still prints one digit.
    always_comb begin
        top_idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] != 4'd0) begin
                top_idx = IDX_W'(i);
            end
        end
    end

    assign cur_digit = bcd_reg[{idx_reg, 2'b00} +: 4];

    always_comb begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        step_next    = step_reg;
        idx_next     = idx_reg;
        neg_next     = neg_reg;
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    neg_next   = s_value[VALUE_W-1];
                    // The most negative value negates to 2^31, which still fits unsigned.
                    mag_next   = s_value[VALUE_W-1] ? (~s_value + 32'd1) : s_value;
                    bcd_next   = '0;
                    step_next  = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next  = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
                mag_next  = {mag_reg[VALUE_W-2:0], 1'b0};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                idx_next   = top_idx;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (neg_reg) begin
                        m_char_next = CHAR_MINUS;
                        m_last_next = 1'b0;
                        neg_next    = 1'b0;
                    end else begin
                        m_char_next = CHAR_ZERO + {4'b0000, cur_digit};
                        m_last_next = (idx_reg == '0);
                        idx_next    = idx_reg - IDX_W'(1);
                        if (idx_reg == '0) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            neg_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            neg_reg     <= neg_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg    <= mag_next;
        bcd_reg    <= bcd_next;
        step_reg   <= step_next;
        idx_reg    <= idx_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    `SITOA_ASSERT_NEXT(a_accept_starts_conv, aclk, aresetn, s_valid && s_ready, state_reg == ST_CONV)
    `SITOA_ASSERT_NOW(a_char_legal, aclk, aresetn, m_valid, (m_character == CHAR_MINUS) || ((m_character >= CHAR_ZERO) && (m_character <= CHAR_NINE)))
    `SITOA_ASSERT_NOW(a_minus_not_last, aclk, aresetn, m_valid && (m_character == CHAR_MINUS), !m_last_char)
    `SITOA_ASSERT_NOW(a_busy_not_ready, aclk, aresetn, state_reg != ST_IDLE, !s_ready)

endmodule

/* tb/sv/sitoa_text_checker.sv */
`timescale 1ns / 1ps
// Checker for the signed integer to decimal text unit: watches both channels,
// predicts the characters of each accepted value and compares them in order.
// Depends on sitoa_pkg for the character codes.
module sitoa_text_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_character,
    input  logic        m_last_char,
    output int          mismatches,
    output int          pending_chars,
    output int          chars_checked
);
    import sitoa_pkg::*;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } text_char_t;

    text_char_t expected_text[$];

    // Queues the decimal text of one value, most significant character first.
    task automatic predict_text(input logic [31:0] value);
        logic [32:0] magnitude;
        logic [3:0]  digit_q[$];
        logic [3:0]  digit;
        // The magnitude is 33 bits wide so that the most negative value needs no special path.
        magnitude = value[31] ? (33'h1_0000_0000 - {1'b0, value}) : {1'b0, value};
        do begin
            digit_q.push_front(4'(magnitude % 33'd10));
            magnitude = magnitude / 33'd10;
        end while (magnitude != 0);
        if (value[31])
            expected_text.push_back('{code: CHAR_MINUS, last: 1'b0});
        while (digit_q.size() > 0) begin
            digit = digit_q.pop_front();
            expected_text.push_back('{code: CHAR_ZERO + 8'(digit),
                                      last: (digit_q.size() == 0)});
        end
    endtask

    always @(posedge aclk) begin
        text_char_t want;
        if (!aresetn) begin
            mismatches    <= 0;
            pending_chars <= 0;
            chars_checked <= 0;
            expected_text.delete();
        end else begin
            if (s_valid && s_ready)
                predict_text(s_value);
            if (m_valid && m_ready) begin
                if (expected_text.size() == 0) begin
                    $display("%0t: unexpected character: expected none, actual %0d last %0b",
                             $time, m_character, m_last_char);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_text.pop_front();
                    chars_checked <= chars_checked + 1;
                    if (m_character !== want.code || m_last_char !== want.last) begin
                        $display("%0t: character mismatch: expected %0d last %0b,",
                                 $time, want.code, want.last,
                                 " actual %0d last %0b", m_character, m_last_char);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            pending_chars <= expected_text.size();
        end
    end

    final begin
        if (expected_text.size() != 0)
            $display("%0t: %0d expected characters never arrived",
                     $time, expected_text.size());
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Top of the testbench: drives values into the decimal text unit in bursts,
// stalls the output on a changing pattern and gives the verdict.
// Depends on sitoa_pkg, the unit itself and sitoa_text_checker.
module tb;
    import sitoa_pkg::*;

    localparam int RANDOM_ITEMS = 150;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 60;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [31:0] s_value     = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [7:0]  m_character;
    logic        m_last_char;

    int mismatches;
    int pending_chars;
    int chars_checked;
    int values_sent   = 0;
    int negatives     = 0;
    int burst_left    = 1;
    int idle_cycles   = 0;
    int stall_mode    = 0;
    int stall_timer   = 0;

    signed_int_to_decimal_ascii_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last_char (m_last_char)
    );

    sitoa_text_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_character   (m_character),
        .m_last_char   (m_last_char),
        .mismatches    (mismatches),
        .pending_chars (pending_chars),
        .chars_checked (chars_checked)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // The output stalls on a randomly chosen pattern that changes whenever its timer runs out.
    always @(posedge aclk) begin
        if (stall_timer == 0) begin
            stall_mode  = $urandom_range(0, 3);
            stall_timer = $urandom_range(20, 120);
        end else begin
            stall_timer = stall_timer - 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (stall_timer % 3 != 0);
        endcase
    end

    // Ends the run when neither channel moves for too long.
    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
        end
        $display("Timeout after %0d idle cycles", IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Presents one value until an edge accepts it; at a burst's end it may add an idle gap.
    task automatic send_value(input logic [31:0] value);
        s_valid <= 1'b1;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        values_sent = values_sent + 1;
        if (value[31])
            negatives = negatives + 1;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
            // Mostly short bursts, now and then a long one without gaps.
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(1, 4);
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                s_value <= $urandom;
                repeat ($urandom_range(1, 50)) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_chars != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    function automatic logic [31:0] random_value();
        longint lo;
        longint hi;
        longint magnitude;
        int     digits;
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: begin
                // A number with a chosen count of digits.
                digits = $urandom_range(1, 10);
                lo = 1;
                repeat (digits - 1) lo = lo * 10;
                hi = (digits == 10) ? 64'd2147483647 : lo * 10 - 1;
                if (digits == 1)
                    lo = 0;
                magnitude = lo + ({$urandom, $urandom} % (hi - lo + 1));
                return $urandom_range(0, 1) ? 32'(-magnitude) : 32'(magnitude);
            end
            3: begin
                // Around a power of ten, where the digit count changes.
                lo = 1;
                repeat ($urandom_range(1, 9)) lo = lo * 10;
                magnitude = lo + $urandom_range(0, 2) - 1;
                return $urandom_range(0, 1) ? 32'(-magnitude) : 32'(magnitude);
            end
            4: return 32'($signed($urandom_range(0, 40)) - 20);
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000 + $urandom_range(0, 3);
                    1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
                    2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
                    default: return {1'b0, 31'($urandom)};
                endcase
            end
        endcase
    endfunction

    initial begin
        logic [31:0] directed[] = '{
            32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF6,
            32'd99, 32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
            32'd999_999_999, 32'd1_000_000_000, 32'hC465_3600, 32'd123_456_789,
            32'hC521_97EF, 32'h5555_5555, 32'hAAAA_AAAA, 32'd1_000_000_009,
            32'hFFFF_FF9C
        };
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i])
            send_value(directed[i]);
        wait_for_drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_value(random_value());
            if (n == RANDOM_ITEMS / 2)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Converted %0d values (%0d negative), %0d characters checked",
                 values_sent, negatives, chars_checked);
        if (mismatches == 0 && pending_chars == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
